FILE: src/iir_tdf2_pkg.sv
package iir_tdf2_pkg;

  localparam int DATA_W    = 16;
  localparam int COEF_W    = 16;
  localparam int DLY_W     = 40;
  localparam int ACC_W     = DLY_W + 2;
  localparam int PROD_W    = DATA_W + COEF_W;
  localparam int DIGIT_W   = 4;
  localparam int ADDR_W    = 5;
  localparam int PDATA_W   = 32;

  localparam int ORDER_DEF          = 2;
  localparam int COEF_FRAC_BITS_DEF = 14;

  typedef enum logic [2:0] {
    REG_B0    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_A1    = 3'd3,
    REG_A2    = 3'd4,
    REG_FIR   = 3'd5,
    REG_ORDER = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic                     fir_mode;
    logic [1:0]               order_in_use;
  } cfg_t;

endpackage

FILE: src/iir_tdf2_regs.sv
module iir_tdf2_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [iir_tdf2_pkg::ADDR_W-1:0]    paddr,
  input  logic [iir_tdf2_pkg::PDATA_W-1:0]   pwdata,
  output logic [iir_tdf2_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output iir_tdf2_pkg::cfg_t                 cfg
);

  localparam int CW = iir_tdf2_pkg::COEF_W;
  localparam int DW = iir_tdf2_pkg::PDATA_W;

  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[iir_tdf2_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.b0           <= CW'(16384);
      cfg.b1           <= '0;
      cfg.b2           <= '0;
      cfg.a1           <= '0;
      cfg.a2           <= '0;
      cfg.fir_mode     <= 1'b0;
      cfg.order_in_use <= 2'd2;
    end else if (wr_en) begin
      unique case (idx)
        iir_tdf2_pkg::REG_B0:    cfg.b0           <= pwdata[CW-1:0];
        iir_tdf2_pkg::REG_B1:    cfg.b1           <= pwdata[CW-1:0];
        iir_tdf2_pkg::REG_B2:    cfg.b2           <= pwdata[CW-1:0];
        iir_tdf2_pkg::REG_A1:    cfg.a1           <= pwdata[CW-1:0];
        iir_tdf2_pkg::REG_A2:    cfg.a2           <= pwdata[CW-1:0];
        iir_tdf2_pkg::REG_FIR:   cfg.fir_mode     <= pwdata[0];
        iir_tdf2_pkg::REG_ORDER: cfg.order_in_use <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      iir_tdf2_pkg::REG_B0:    prdata = DW'(unsigned'(cfg.b0));
      iir_tdf2_pkg::REG_B1:    prdata = DW'(unsigned'(cfg.b1));
      iir_tdf2_pkg::REG_B2:    prdata = DW'(unsigned'(cfg.b2));
      iir_tdf2_pkg::REG_A1:    prdata = DW'(unsigned'(cfg.a1));
      iir_tdf2_pkg::REG_A2:    prdata = DW'(unsigned'(cfg.a2));
      iir_tdf2_pkg::REG_FIR:   prdata = DW'(cfg.fir_mode);
      iir_tdf2_pkg::REG_ORDER: prdata = DW'(cfg.order_in_use);
      default:                 prdata = '0;
    endcase
  end

endmodule

FILE: src/iir_tdf2_mul.sv
module iir_tdf2_mul (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic signed [iir_tdf2_pkg::COEF_W-1:0]   coef,
  input  logic signed [iir_tdf2_pkg::DATA_W-1:0]   operand,
  output logic                                     done,
  output logic signed [iir_tdf2_pkg::PROD_W-1:0]   product
);

  localparam int CW    = iir_tdf2_pkg::COEF_W;
  localparam int XW    = iir_tdf2_pkg::DATA_W;
  localparam int DG    = iir_tdf2_pkg::DIGIT_W;
  localparam int NDIG  = XW / DG;
  localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int HI_W  = CW + 2;
  localparam int PP_W  = CW + DG + 1;
  localparam int SUM_W = HI_W + DG;

  logic                     busy;
  logic [CNT_W-1:0]         cnt;
  logic signed [CW-1:0]     mcand;
  logic [XW-1:0]            mplier;
  logic signed [HI_W-1:0]   hi;
  logic [XW-1:0]            lo;

  logic                     last;
  logic signed [DG:0]       digit;
  logic signed [PP_W-1:0]   pp;
  logic signed [SUM_W-1:0]  sum;

  // top digit of the operand carries its sign
  assign last    = (cnt == CNT_W'(NDIG - 1));
  assign digit   = {last & mplier[DG-1], mplier[DG-1:0]};
  assign pp      = mcand * digit;
  assign sum     = SUM_W'(hi) + SUM_W'(pp);
  assign product = {hi[CW-1:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        mcand  <= coef;
        mplier <= operand;
        hi     <= '0;
      end else if (busy) begin
        mplier <= mplier >> DG;
        hi     <= sum[SUM_W-1:DG];
        lo     <= {sum[DG-1:0], lo[XW-1:DG]};
        cnt    <= cnt + CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/iir_transposed_df2_filter.sv
// Transposed direct form II IIR filter, order one or two, on signed Q1.15
// samples with Q2.14 coefficients set over the APB port. Each transaction on
// the sample side yields one transaction on the output side: y = round(b0*x +
// d0) saturated to 16 bits, with clipped set when y or a 40-bit delay state
// saturated. All five products go through one shared digit-serial multiplier
// that takes four bits of the sample or output per cycle; a sample is only
// accepted once the previous one has gone through every product step and into
// the output register. While a finished result waits there, the next sample
// is accepted. The delay line is cleared by reset.
module iir_transposed_df2_filter #(
  parameter int ORDER          = iir_tdf2_pkg::ORDER_DEF,
  parameter int COEF_FRAC_BITS = iir_tdf2_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [iir_tdf2_pkg::ADDR_W-1:0]         paddr,
  input  logic [iir_tdf2_pkg::PDATA_W-1:0]        pwdata,
  output logic [iir_tdf2_pkg::PDATA_W-1:0]        prdata,
  output logic                                    pready,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [iir_tdf2_pkg::DATA_W-1:0]  sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [iir_tdf2_pkg::DATA_W-1:0]  filtered,
  output logic                                    clipped
);

  localparam int XW   = iir_tdf2_pkg::DATA_W;
  localparam int CW   = iir_tdf2_pkg::COEF_W;
  localparam int DW   = iir_tdf2_pkg::DLY_W;
  localparam int AW   = iir_tdf2_pkg::ACC_W;
  localparam int PW   = iir_tdf2_pkg::PROD_W;
  localparam logic signed [AW-1:0] RND = AW'(1) << (COEF_FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_B0, S_Y, S_B1, S_A1, S_N0, S_B2, S_A2, S_N1, S_OUT
  } state_t;

  iir_tdf2_pkg::cfg_t cfg;

  state_t                state;
  logic signed [XW-1:0]  x;
  logic signed [XW-1:0]  y;
  logic signed [AW-1:0]  acc;
  logic signed [DW-1:0]  d0;
  logic signed [DW-1:0]  d1;
  logic                  clip;
  logic                  mul_start;
  logic signed [CW-1:0]  mul_coef;
  logic signed [XW-1:0]  mul_op;
  logic                  mul_done;
  logic signed [PW-1:0]  mul_prod;

  logic                  second;
  logic                  fb;
  logic signed [AW-1:0]  prod_ext;
  logic signed [AW-1:0]  acc_shr;
  logic                  y_ovf;
  logic signed [XW-1:0]  y_sat;
  logic                  d_ovf;
  logic signed [DW-1:0]  d_sat;

  iir_tdf2_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  iir_tdf2_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .coef    (mul_coef),
    .operand (mul_op),
    .done    (mul_done),
    .product (mul_prod)
  );

  assign second   = (ORDER >= 2) && (cfg.order_in_use != 2'd1);
  assign fb       = !cfg.fir_mode;
  assign in_ready = (state == S_IDLE);
  assign prod_ext = AW'(mul_prod);

  assign acc_shr = acc >>> COEF_FRAC_BITS;
  assign y_ovf   = (acc_shr[AW-1:XW-1] != {(AW-XW+1){acc_shr[XW-1]}});
  assign y_sat   = y_ovf ? (acc_shr[AW-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}})
                         : acc_shr[XW-1:0];

  assign d_ovf = (acc[AW-1:DW-1] != {(AW-DW+1){acc[DW-1]}});
  assign d_sat = d_ovf ? (acc[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                       : acc[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      d0        <= '0;
      d1        <= '0;
      mul_start <= 1'b0;
      out_valid <= 1'b0;
      clip      <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      if (out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            x         <= sample;
            acc       <= AW'(d0) + RND;
            clip      <= 1'b0;
            mul_coef  <= cfg.b0;
            mul_op    <= sample;
            mul_start <= 1'b1;
            state     <= S_B0;
          end
        end
        S_B0: begin
          if (mul_done) begin
            acc   <= acc + prod_ext;
            state <= S_Y;
          end
        end
        S_Y: begin
          y         <= y_sat;
          clip      <= clip | y_ovf;
          acc       <= second ? AW'(d1) : '0;
          mul_coef  <= cfg.b1;
          mul_op    <= x;
          mul_start <= 1'b1;
          state     <= S_B1;
        end
        S_B1: begin
          if (mul_done) begin
            acc       <= acc + prod_ext;
            mul_coef  <= fb ? cfg.a1 : '0;
            mul_op    <= y;
            mul_start <= 1'b1;
            state     <= S_A1;
          end
        end
        S_A1: begin
          if (mul_done) begin
            acc   <= acc - prod_ext;
            state <= S_N0;
          end
        end
        S_N0: begin
          d0        <= d_sat;
          clip      <= clip | d_ovf;
          acc       <= '0;
          mul_coef  <= second ? cfg.b2 : '0;
          mul_op    <= x;
          mul_start <= 1'b1;
          state     <= S_B2;
        end
        S_B2: begin
          if (mul_done) begin
            acc       <= acc + prod_ext;
            mul_coef  <= (second && fb) ? cfg.a2 : '0;
            mul_op    <= y;
            mul_start <= 1'b1;
            state     <= S_A2;
          end
        end
        S_A2: begin
          if (mul_done) begin
            acc   <= acc - prod_ext;
            state <= S_N1;
          end
        end
        S_N1: begin
          d1    <= second ? d_sat : '0;
          clip  <= clip | (second & d_ovf);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            filtered  <= y;
            clipped   <= clip;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_mul_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_B0 || state == S_B1 || state == S_A1 ||
                  state == S_B2 || state == S_A2))
    else $error("multiplier result arrived outside a product step");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!in_ready && state == S_B0))
    else $error("sample transaction did not start the b0 product");

  a_d1_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_N1 && !second) |=> (d1 == '0))
    else $error("second delay not held at zero at order one");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("finished result not loaded into output register");

endmodule

FILE: sim/tb_iir_transposed_df2_filter.sv
`timescale 1ns / 1ps

module tb_iir_transposed_df2_filter;

  localparam int DATA_W  = iir_tdf2_pkg::DATA_W;
  localparam int COEF_W  = iir_tdf2_pkg::COEF_W;
  localparam int DLY_W   = iir_tdf2_pkg::DLY_W;
  localparam int ADDR_W  = iir_tdf2_pkg::ADDR_W;
  localparam int PDATA_W = iir_tdf2_pkg::PDATA_W;

  typedef iir_tdf2_pkg::cfg_t cfg_t;

  localparam int FILT_ORDER = iir_tdf2_pkg::ORDER_DEF;
  localparam int CFRAC      = iir_tdf2_pkg::COEF_FRAC_BITS_DEF;
  localparam longint DLY_HI = (longint'(1) <<< (DLY_W - 1)) - 1;
  localparam longint DLY_LO = -DLY_HI - 1;

  localparam int REG_B0       = iir_tdf2_pkg::REG_B0;
  localparam int REG_B1       = iir_tdf2_pkg::REG_B1;
  localparam int REG_B2       = iir_tdf2_pkg::REG_B2;
  localparam int REG_A1       = iir_tdf2_pkg::REG_A1;
  localparam int REG_A2       = iir_tdf2_pkg::REG_A2;
  localparam int REG_FIR      = iir_tdf2_pkg::REG_FIR;
  localparam int REG_ORDER    = iir_tdf2_pkg::REG_ORDER;
  localparam int REG_UNMAPPED = 7;

  localparam int RX_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS    = 97;
  localparam int NUM_PHASES     = 7;

  typedef struct {
    logic signed [DATA_W-1:0] y;
    logic                     clip;
  } filt_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [PDATA_W-1:0]        pwdata = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [DATA_W-1:0]  sample = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [DATA_W-1:0]  filtered;
  logic                      clipped;

  cfg_t         coef_set;
  longint       delay_state [2];
  filt_result_t pending_outputs [$];
  filt_result_t want;

  int mismatches      = 0;
  int results_checked = 0;
  int samples_sent    = 0;
  int settings_used   = 0;
  int tx_idle_pct     = 0;
  int rx_idle_pct     = 0;
  int rx_hold_left    = 0;
  int rx_stall_left   = 0;

  iir_transposed_df2_filter #(
    .ORDER(FILT_ORDER),
    .COEF_FRAC_BITS(CFRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .filtered(filtered),
    .clipped(clipped)
  );

  always #6 clk = ~clk;

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 50) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic int idle_len(int pct);
    int r;
    if (pct == 0 || $urandom_range(99) >= pct) return 0;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(12, 70);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(19))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic longint clamp_delay(longint v, inout bit clip);
    if (v > DLY_HI) begin
      clip = 1'b1;
      return DLY_HI;
    end
    if (v < DLY_LO) begin
      clip = 1'b1;
      return DLY_LO;
    end
    return v;
  endfunction

  // one filter step on the shadow state, queues the expected output
  function automatic void predict_filter_step(logic signed [DATA_W-1:0] x);
    longint xs, acc, y, n0, n1;
    bit clip, two_taps, feedback;
    filt_result_t res;
    clip     = 1'b0;
    xs       = longint'(x);
    two_taps = (FILT_ORDER >= 2) && (coef_set.order_in_use != 2'd1);
    feedback = !coef_set.fir_mode;

    acc = longint'($signed(coef_set.b0)) * xs + delay_state[0]
          + (longint'(1) <<< (CFRAC - 1));
    y = acc >>> CFRAC;
    if (y > 32767) begin
      y = 32767;
      clip = 1'b1;
    end
    if (y < -32768) begin
      y = -32768;
      clip = 1'b1;
    end

    n0 = longint'($signed(coef_set.b1)) * xs;
    if (feedback) n0 -= longint'($signed(coef_set.a1)) * y;
    if (two_taps) begin
      n0 += delay_state[1];
      n1 = longint'($signed(coef_set.b2)) * xs;
      if (feedback) n1 -= longint'($signed(coef_set.a2)) * y;
      n1 = clamp_delay(n1, clip);
    end else begin
      n1 = 0;
    end
    delay_state[0] = clamp_delay(n0, clip);
    delay_state[1] = n1;

    res.y    = y[DATA_W-1:0];
    res.clip = clip;
    pending_outputs.push_back(res);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("output transaction with none expected: filtered=%0d",
                                  filtered));
      end else begin
        want = pending_outputs.pop_front();
        results_checked++;
        if (filtered !== want.y)
          report_mismatch($sformatf("result %0d: filtered=%0d expected %0d",
                                    results_checked, filtered, want.y));
        if (clipped !== want.clip)
          report_mismatch($sformatf("result %0d: clipped=%0b expected %0b",
                                    results_checked, clipped, want.clip));
      end
    end
  end

  // output side: long hold-off on request, else random stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left = rx_stall_left - 1;
    end else begin
      rx_stall_left = idle_len(rx_idle_pct);
      if (rx_stall_left > 0) begin
        out_ready <= 1'b0;
        rx_stall_left = rx_stall_left - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic apb_access(bit write_op, int idx, logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_op;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (write_op) begin
      case (idx)
        REG_B0:    coef_set.b0 = wdata[COEF_W-1:0];
        REG_B1:    coef_set.b1 = wdata[COEF_W-1:0];
        REG_B2:    coef_set.b2 = wdata[COEF_W-1:0];
        REG_A1:    coef_set.a1 = wdata[COEF_W-1:0];
        REG_A2:    coef_set.a2 = wdata[COEF_W-1:0];
        REG_FIR:   coef_set.fir_mode = wdata[0];
        REG_ORDER: coef_set.order_in_use = wdata[1:0];
        default: ;
      endcase
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_filter(logic signed [COEF_W-1:0] b0, logic signed [COEF_W-1:0] b1,
                            logic signed [COEF_W-1:0] b2, logic signed [COEF_W-1:0] a1,
                            logic signed [COEF_W-1:0] a2, logic fir, logic [1:0] order);
    logic [PDATA_W-1:0] unused;
    apb_access(1'b1, REG_B0, {16'($urandom), b0}, unused);
    apb_access(1'b1, REG_B1, {16'($urandom), b1}, unused);
    apb_access(1'b1, REG_B2, {16'($urandom), b2}, unused);
    apb_access(1'b1, REG_A1, {16'($urandom), a1}, unused);
    apb_access(1'b1, REG_A2, {16'($urandom), a2}, unused);
    apb_access(1'b1, REG_FIR, {31'($urandom), fir}, unused);
    apb_access(1'b1, REG_ORDER, {30'($urandom), order}, unused);
    settings_used++;
  endtask

  task automatic check_registers();
    logic [PDATA_W-1:0] got, reg_want, reg_mask;
    for (int i = REG_B0; i <= REG_ORDER; i++) begin
      apb_access(1'b0, i, '0, got);
      reg_mask = 32'h0000_FFFF;
      case (i)
        REG_B0: reg_want = {16'h0, coef_set.b0};
        REG_B1: reg_want = {16'h0, coef_set.b1};
        REG_B2: reg_want = {16'h0, coef_set.b2};
        REG_A1: reg_want = {16'h0, coef_set.a1};
        REG_A2: reg_want = {16'h0, coef_set.a2};
        REG_FIR: begin
          reg_want = {31'h0, coef_set.fir_mode};
          reg_mask = 32'h1;
        end
        default: begin
          reg_want = {30'h0, coef_set.order_in_use};
          reg_mask = 32'h3;
        end
      endcase
      if ((got & reg_mask) !== (reg_want & reg_mask))
        report_mismatch($sformatf("register %0d reads 0x%0h, expected 0x%0h",
                                  i, got & reg_mask, reg_want & reg_mask));
    end
  endtask

  task automatic send_sample(logic signed [DATA_W-1:0] x);
    int gap;
    gap = idle_len(tx_idle_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      sample   <= 16'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_filter_step(x);
    samples_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic test_reset_passthrough();
    check_registers();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    wait_idle();
  endtask

  task automatic test_register_map();
    logic [PDATA_W-1:0] unused;
    set_filter(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 1'($urandom), 2'($urandom));
    check_registers();
    // writes past the last register are dropped
    apb_access(1'b1, REG_UNMAPPED, $urandom, unused);
    check_registers();
  endtask

  task automatic test_output_saturation();
    set_filter(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1, 2'd2);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    wait_idle();
  endtask

  task automatic test_order_and_fir_modes();
    set_filter(16'sh4000, 16'sh2000, 16'sh1000, 16'sh8000, 16'sh7FFF, 1'b0, 2'd1);
    send_sample(16'sh1234);
    send_sample(16'shC000);
    send_sample(16'sh0100);
    wait_idle();
    set_filter(16'sh2000, 16'shE000, 16'sh1800, 16'shC000, 16'sh2000, 1'b0, 2'd0);
    send_sample(16'sh4000);
    send_sample(16'shF000);
    wait_idle();
    set_filter(16'sh2000, 16'shE000, 16'sh1800, 16'shC000, 16'sh2000, 1'b0, 2'd3);
    send_sample(16'sh4000);
    send_sample(16'sh7FFF);
    wait_idle();
    // nonzero a-terms must have no effect in FIR mode
    set_filter(16'sh3000, 16'sh1000, 16'shF000, 16'sh7FFF, 16'sh8000, 1'b1, 2'd2);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh2222);
    wait_idle();
  endtask

  task automatic test_random_filters();
    int kind;
    for (int p = 0; p < NUM_PHASES; p++) begin
      kind = (p < 5) ? p : $urandom_range(2, 4);
      case (p % 3)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 30; rx_idle_pct = 60; end
        default: begin tx_idle_pct = 60; rx_idle_pct = 30; end
      endcase
      case (kind)
        0: set_filter(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 2'd2);
        1: set_filter(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 2'd3);
        2: set_filter(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 1'($urandom), 2'($urandom));
        3: set_filter(16'(int'($urandom_range(16384)) - 8192),
                      16'(int'($urandom_range(16384)) - 8192),
                      16'(int'($urandom_range(16384)) - 8192),
                      16'(int'($urandom_range(32768)) - 16384),
                      16'($urandom_range(8192)), 1'b0, 2'($urandom_range(1, 2)));
        default: set_filter(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 1'($urandom), 2'd1);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_sample());
      wait_idle();
    end
  endtask

  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_filter(16'sh2000, 16'sh1000, 16'shF800, 16'shE000, 16'sh0800, 1'b0, 2'd2);
    @(posedge clk);
    rx_hold_left = RX_HOLD_CYCLES;
    for (int i = 0; i < 10; i++) send_sample(pick_sample());
    wait_idle();
  endtask

  initial begin
    coef_set.b0           = 16'sd16384;
    coef_set.b1           = '0;
    coef_set.b2           = '0;
    coef_set.a1           = '0;
    coef_set.a2           = '0;
    coef_set.fir_mode     = 1'b0;
    coef_set.order_in_use = 2'd2;
    delay_state[0]        = 0;
    delay_state[1]        = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_passthrough();
    test_register_map();
    test_output_saturation();
    test_order_and_fir_modes();
    test_random_filters();
    test_output_backpressure();
    wait_idle();

    $display("Covered %0d samples over %0d coefficient settings: orders 1 and 2,",
             samples_sent, settings_used);
    $display("FIR and IIR modes, output clipping, register readback, %0d outputs checked.",
             results_checked);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/iir_tdf2_pkg.sv
src/iir_tdf2_regs.sv
src/iir_tdf2_mul.sv
src/iir_transposed_df2_filter.sv
sim/tb_iir_transposed_df2_filter.sv
